// ----- rtl/rpl_pkg.sv -----
// Shared types and constants for the region penalty lookup.
`timescale 1ns / 1ps
package rpl_pkg;
   localparam int MaxRegionsDefault = 16;
   localparam int WordsPerRegion    = 12;
   localparam int RegionBits        = WordsPerRegion * 32;
   localparam logic signed [63:0] FxPi    = 64'sd205887;
   localparam logic signed [63:0] FxTwoPi = 64'sd411775;

   localparam logic [1:0] MODE_QUERY  = 2'd0;
   localparam logic [1:0] MODE_WRITE  = 2'd1;
   localparam logic [1:0] MODE_COMMIT = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic [3:0]         word_select;
      logic signed [31:0] word_value;
      logic [7:0]         query_action;
      logic signed [15:0] cell_x;
      logic signed [15:0] cell_y;
      logic signed [15:0] cell_z;
      logic signed [15:0] cell_yaw;
      logic signed [15:0] cell_prox;
      logic signed [15:0] cell_distal;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [3:0]  hit_index;
      logic [31:0] penalty;
      logic        status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCALE, ST_READ, ST_EVAL, ST_SQ, ST_DONE
   } state_type;
endpackage

// ----- rtl/region_penalty_lookup.sv -----
// Top level of the region penalty lookup.
// A write, commit or clear request goes from idle to the done state, which raises valid;
// a query runs one scale step, then read, eval and square per region walked until a hit
// or the last region, then the done state raises valid. One item at a time: the next
// input is accepted only in idle, once the response has transferred.
// Synchronous active-high reset clears count, staging words, cell sizes (1.0) and the
// output register; the region memory is not cleared.
`timescale 1ns / 1ps
module region_penalty_lookup #(
   parameter int MaxRegions = rpl_pkg::MaxRegionsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rpl_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rpl_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import rpl_pkg::*;
   localparam int AddrW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
   localparam int CntW  = $clog2(MaxRegions + 1);

   state_type state_ff, state_in;
   logic [31:0] res_ff [6];
   logic [31:0] stage_ff [WordsPerRegion];
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] idx_ff, idx_in;
   req_type q_ff;
   logic signed [63:0] pos_ff [6];
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Evaluation registers for the current region.
   logic pre_ok_ff;
   logic [31:0] abs_ff [3];
   logic [63:0] r2_ff;
   logic [31:0] pen_ff;

   logic [RegionBits-1:0] row, stage_row;
   logic wr_en;

   always_comb begin
      for (int i = 0; i < WordsPerRegion; i++) begin
         stage_row[i*32 +: 32] = stage_ff[i];
      end
   end

   assign wr_en = (state_ff == ST_IDLE) && req_valid && !rsp_valid_ff &&
                  (req_data.mode == MODE_COMMIT) && (count_ff < CntW'(MaxRegions));

   rpl_store #(.MaxRegions(MaxRegions), .AddrW(AddrW)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AddrW-1:0]),
      .wr_data(stage_row),
      .rd_addr(idx_ff[AddrW-1:0]),
      .rd_data(row)
   );

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Region tests on the freshly read row; the squares use registered magnitudes.
   logic signed [63:0] d [6];
   logic signed [63:0] r, ro, rp, rd, yd;
   logic [63:0] ad [6];
   logic pre_ok;
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         d[i]  = 64'(signed'(row[(i+1)*32 +: 32])) - pos_ff[i];
         ad[i] = d[i][63] ? 64'(-d[i]) : 64'(d[i]);
      end
      r  = 64'(signed'(row[7*32 +: 32]));
      ro = 64'(signed'(row[8*32 +: 32]));
      rp = 64'(signed'(row[9*32 +: 32]));
      rd = 64'(signed'(row[10*32 +: 32]));
      yd = d[3];
      if (yd > FxPi) begin
         yd = yd - FxTwoPi;
      end else if (yd < -FxPi) begin
         yd = yd + FxTwoPi;
      end
      pre_ok = (row[31:0] == {24'd0, q_ff.query_action}) && !r[63] &&
               ($signed(ad[0]) <= r) && ($signed(ad[1]) <= r) && ($signed(ad[2]) <= r) &&
               ((yd[63] ? -yd : yd) <= ro) &&
               ($signed(ad[4]) <= rp) && ($signed(ad[5]) <= rd);
   end

   // Squares are below 2^62 each since |d| <= r < 2^31.
   logic [63:0] sq_sum;
   always_comb begin
      sq_sum = 64'(abs_ff[0]) * 64'(abs_ff[0]) + 64'(abs_ff[1]) * 64'(abs_ff[1]) +
               64'(abs_ff[2]) * 64'(abs_ff[2]);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               state_in = (req_data.mode == MODE_QUERY) ? ST_SCALE : ST_DONE;
            end
         end
         ST_SCALE: state_in = (count_ff == '0) ? ST_DONE : ST_READ;
         ST_READ:  state_in = ST_EVAL;
         ST_EVAL:  state_in = ST_SQ;
         ST_SQ: begin
            if ((pre_ok_ff && sq_sum <= r2_ff) || (idx_ff + 1'b1 >= count_ff)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            // Hold the pending response until a new request transfers.
            if (req_valid && req_ready) begin
               idx_in = '0;
               rsp_in = '0;
               case (req_data.mode)
                  MODE_COMMIT: begin
                     if (count_ff < CntW'(MaxRegions)) begin
                        count_in = count_ff + 1'b1;
                     end else begin
                        rsp_in.status = 1'b1;
                     end
                  end
                  MODE_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         ST_SQ: begin
            if (pre_ok_ff && sq_sum <= r2_ff) begin
               rsp_in.hit       = 1'b1;
               rsp_in.hit_index = 4'(idx_ff);
               rsp_in.penalty   = pen_ff;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) res_ff[i] <= 32'd65536;
         for (int i = 0; i < WordsPerRegion; i++) stage_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_ff       <= rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_index < 3'd6) begin
            res_ff[csr_index] <= csr_data;
         end
         if (state_ff == ST_IDLE && req_valid && req_ready &&
             req_data.mode == MODE_WRITE && req_data.word_select < 4'd12) begin
            stage_ff[req_data.word_select] <= req_data.word_value;
         end
      end
   end

   // Payload registers: hold the query, scale each cell (one 16x33 product per axis).
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && req_ready) begin
         q_ff <= req_data;
      end
      if (state_ff == ST_SCALE) begin
         pos_ff[0] <= 64'(q_ff.cell_x)      * 64'(signed'({1'b0, res_ff[0]}));
         pos_ff[1] <= 64'(q_ff.cell_y)      * 64'(signed'({1'b0, res_ff[1]}));
         pos_ff[2] <= 64'(q_ff.cell_z)      * 64'(signed'({1'b0, res_ff[2]}));
         pos_ff[3] <= 64'(q_ff.cell_yaw)    * 64'(signed'({1'b0, res_ff[3]}));
         pos_ff[4] <= 64'(q_ff.cell_prox)   * 64'(signed'({1'b0, res_ff[4]}));
         pos_ff[5] <= 64'(q_ff.cell_distal) * 64'(signed'({1'b0, res_ff[5]}));
      end
      if (state_ff == ST_EVAL) begin
         pre_ok_ff <= pre_ok;
         abs_ff[0] <= ad[0][31:0];
         abs_ff[1] <= ad[1][31:0];
         abs_ff[2] <= ad[2][31:0];
         r2_ff     <= 64'(r[31:0]) * 64'(r[31:0]);
         pen_ff    <= row[11*32 +: 32];
      end
   end
endmodule

// ----- rtl/rpl_store.sv -----
// Region memory: one 384-bit row per region, registered read.
`timescale 1ns / 1ps
module rpl_store #(
   parameter int MaxRegions = rpl_pkg::MaxRegionsDefault,
   parameter int AddrW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AddrW-1:0]              wr_addr,
   input  logic [rpl_pkg::RegionBits-1:0] wr_data,
   input  logic [AddrW-1:0]              rd_addr,
   output logic [rpl_pkg::RegionBits-1:0] rd_data
);
   import rpl_pkg::*;
   logic [RegionBits-1:0] mem [MaxRegions];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the region penalty lookup block.
`timescale 1ns / 1ps
module tb;
   import rpl_pkg::*;

   localparam int Regions   = 16;
   localparam int TailWait  = 2 + 4 * Regions + 16;

   // Table model: cell sizes, stored regions and the staging words. It
   // computes the expected response of every accepted request.
   class penalty_scoreboard;
      bit [31:0] cell_size[6];
      bit [31:0] region_word[Regions][WordsPerRegion];
      int        region_cnt;
      bit [31:0] stage_word[WordsPerRegion];
      rsp_type   pending_rsp[$];
      int        mismatches, queries, hits, refused, clears;

      function new();
         foreach (cell_size[i]) cell_size[i] = 32'd65536;
         foreach (stage_word[i]) stage_word[i] = '0;
         region_cnt = 0;
      endfunction

      function void set_reg(bit [2:0] idx, bit [31:0] val);
         if (idx < 6) cell_size[idx] = val;
      endfunction

      function longint mag(longint v);
         return (v < 0) ? -v : v;
      endfunction

      function bit region_hit(int k, bit [7:0] act, longint pos[6]);
         longint    d[6];
         longint    rad;
         bit [63:0] a, sum;
         if (region_word[k][0] != {24'h0, act}) return 0;
         for (int i = 0; i < 6; i++)
            d[i] = longint'($signed(region_word[k][1 + i])) - pos[i];
         rad = longint'($signed(region_word[k][7]));
         if (rad < 0) return 0;
         sum = '0;
         for (int i = 0; i < 3; i++) begin
            if (mag(d[i]) > rad) return 0;
            a = mag(d[i]);
            sum += a * a;
         end
         if (sum > 64'(rad) * 64'(rad)) return 0;
         // fold the yaw difference once by a full turn
         if (d[3] > FxPi) d[3] -= FxTwoPi;
         else if (d[3] < -FxPi) d[3] += FxTwoPi;
         if (mag(d[3]) > longint'($signed(region_word[k][8]))) return 0;
         if (mag(d[4]) > longint'($signed(region_word[k][9]))) return 0;
         if (mag(d[5]) > longint'($signed(region_word[k][10]))) return 0;
         return 1;
      endfunction

      // Advance the table by one accepted request and queue its response.
      function void note(req_type q);
         rsp_type r;
         longint  pos[6];
         logic signed [15:0] grid_cell[6];
         r = '0;
         case (q.mode)
            MODE_QUERY: begin
               grid_cell = '{q.cell_x, q.cell_y, q.cell_z, q.cell_yaw, q.cell_prox,
                             q.cell_distal};
               for (int i = 0; i < 6; i++)
                  pos[i] = longint'(grid_cell[i]) * longint'({32'h0, cell_size[i]});
               queries++;
               for (int k = 0; k < region_cnt; k++)
                  if (region_hit(k, q.query_action, pos)) begin
                     r.hit = 1;
                     r.hit_index = 4'(k);
                     r.penalty = region_word[k][11];
                     hits++;
                     break;
                  end
            end
            MODE_WRITE:
               if (q.word_select < WordsPerRegion) stage_word[q.word_select] = q.word_value;
            MODE_COMMIT:
               if (region_cnt < Regions) begin
                  region_word[region_cnt] = stage_word;
                  region_cnt++;
               end else begin
                  r.status = 1;
                  refused++;
               end
            default: begin
               region_cnt = 0;
               clears++;
            end
         endcase
         pending_rsp = {pending_rsp, r};
      endfunction

      // Compare one response transfer with the oldest expectation.
      function void check(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         want = pending_rsp.pop_front();
         if (got.hit !== want.hit || got.hit_index !== want.hit_index ||
             got.penalty !== want.penalty || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected hit=%0d idx=%0d pen=%h st=%0d,",
                         " got hit=%0d idx=%0d pen=%h st=%0d"},
                        want.hit, want.hit_index, want.penalty, want.status,
                        got.hit, got.hit_index, got.penalty, got.status);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0, req_ready;
   req_type req_data = '0;
   logic    rsp_valid, rsp_ready = 0;
   rsp_type rsp_data;
   logic    csr_valid = 0, csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   penalty_scoreboard table_model = new();
   int idle_pct = 0, stall_pct = 0, hold_cycles = 0, sent = 0;

   // generator's view of the regions it has committed, used to aim queries
   int aim_cell[Regions][6];
   int aim_act[Regions];
   int aim_cnt = 0;
   int stage_cell[6];
   int stage_act;

   always #4 clock = ~clock;

   region_penalty_lookup dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Check every response transfer on the rising edge.
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) table_model.check(rsp_data);

   // Receiver: stall at random, or hold off entirely while hold_cycles runs down.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready = 0;
            hold_cycles--;
         end else
            rsp_ready = ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   // Offer one request; idle at random first, hold it until the transfer.
   task automatic send(input req_type it);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_data  = it;
      do @(posedge clock); while (!req_ready);
      table_model.note(it);
      sent++;
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      req_valid = 0;
      csr_valid = 1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      table_model.set_reg(idx, val);
      @(negedge clock);
      csr_valid = 0;
   endtask

   // Drop valid, let every expected response arrive, then let the block settle.
   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (table_model.pending_rsp.size() != 0) @(posedge clock);
      repeat (TailWait) @(posedge clock);
   endtask

   function automatic req_type noise_req(logic [1:0] m);
      req_type      q;
      logic [159:0] rnd;
      rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
      q = rnd[$bits(req_type)-1:0];
      q.mode = m;
      return q;
   endfunction

   function automatic logic [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   task automatic put_word(input int sel, input logic [31:0] val);
      req_type q;
      q = noise_req(MODE_WRITE);
      q.word_select = 4'(sel);
      q.word_value  = val;
      send(q);
   endtask

   task automatic commit();
      send(noise_req(MODE_COMMIT));
      if (aim_cnt < Regions) begin
         aim_cell[aim_cnt] = stage_cell;
         aim_act[aim_cnt]  = stage_act;
         aim_cnt++;
      end
   endtask

   task automatic clear();
      send(noise_req(MODE_CLEAR));
      aim_cnt = 0;
   endtask

   task automatic query(input int act, input int c[6]);
      req_type q;
      q = noise_req(MODE_QUERY);
      q.query_action = 8'(act);
      q.cell_x = 16'(c[0]); q.cell_y = 16'(c[1]); q.cell_z = 16'(c[2]);
      q.cell_yaw = 16'(c[3]); q.cell_prox = 16'(c[4]); q.cell_distal = 16'(c[5]);
      send(q);
   endtask

   // Load a full region around random target cells, words in a random order,
   // sometimes skipping one so stale staging content gets stored.
   task automatic load_region();
      int          order[WordsPerRegion];
      longint      sz;
      logic [31:0] val;
      foreach (order[i]) order[i] = i;
      order.shuffle();
      for (int i = 0; i < 6; i++) stage_cell[i] = $urandom_range(0, 6) - 3;
      stage_act = ($urandom_range(0, 19) == 0) ? 256 + $urandom_range(0, 9) :
                  $urandom_range(0, 3);
      foreach (order[n]) begin
         int w;
         w = order[n];
         if ($urandom_range(0, 29) == 0) continue;
         if (w == 0)
            val = stage_act;
         else if (w <= 6) begin
            sz  = longint'({32'h0, table_model.cell_size[w - 1]});
            val = sat32(stage_cell[w - 1] * sz + (longint'($urandom_range(0, 64)) - 32) * (sz / 128));
         end else if (w <= 10) begin
            sz  = longint'({32'h0, table_model.cell_size[(w == 7) ? 0 : w - 5]});
            val = ($urandom_range(0, 9) == 0) ? 32'h8000_0000 | $urandom :
                  sat32(longint'($urandom_range(0, 40)) * sz / 10);
         end else
            val = $urandom;
         put_word(w, val);
      end
      commit();
   endtask

   // Run one phase of random traffic, mostly well-formed loads and aimed queries.
   task automatic random_traffic(input int count, input bit hold_off, input bit pause);
      int c[6];
      int k, pick, start;
      start = sent;
      while (sent - start < count) begin
         if (hold_off && sent - start == count / 3) hold_cycles = 400;
         if (pause && sent - start == count / 2) drain();
         pick = $urandom_range(0, 99);
         if (pick < 42 && aim_cnt > 0) begin
            k = $urandom_range(0, aim_cnt - 1);
            for (int i = 0; i < 6; i++) c[i] = aim_cell[k][i] + $urandom_range(0, 2) - 1;
            query(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : aim_act[k], c);
         end else if (pick < 55)
            send(noise_req(MODE_QUERY));
         else if (pick < 85)
            load_region();
         else if (pick < 90)
            commit();
         else if (pick < 96)
            send(noise_req(MODE_WRITE));
         else if ($urandom_range(0, 2) == 0)
            clear();
         else
            commit();
      end
   endtask

   initial begin
      int zero6[6];
      int c[6];
      int stall_set[4];
      int idle_set[4];
      zero6 = '{0, 0, 0, 0, 0, 0};
      idle_set  = '{0, 87, 0, 6};
      stall_set = '{0, 0, 87, 6};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed part at reset cell sizes (1.0 each).
      query(0, zero6);                      // empty table
      put_word(14, 32'hDEAD_BEEF);          // word select out of range
      stage_cell = zero6; stage_act = 0;
      commit();                             // all-zero region 0
      query(0, zero6);                      // hit with zero radius and penalty
      put_word(0, 255);
      put_word(7, 32'h7FFF_FFFF);
      put_word(8, 32'h7FFF_FFFF);
      put_word(9, 32'h7FFF_FFFF);
      put_word(10, 32'h7FFF_FFFF);
      put_word(11, 32'hFFFF_FFFF);
      put_word(4, 32'd205887);              // yaw center at pi
      stage_act = 255;
      commit();
      c = '{32767, 0, 0, 0, 0, 0};
      query(255, c);
      c = '{-32768, 0, 0, 0, 0, 0};
      query(255, c);                        // just beyond the position radius
      c = '{0, 0, 0, -4, -32768, 32767};
      query(255, c);                        // yaw difference folds once
      put_word(0, 256);                     // action outside the query range
      stage_act = 256;
      commit();
      put_word(0, 0);
      put_word(7, 32'h8000_0000);           // negative radius
      commit();
      c = '{1, 0, 0, 0, 0, 0};
      query(0, c);
      clear();
      query(255, zero6);

      // Random phases, each with its own cell sizes and idling pattern.
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         for (int r = 0; r < 6; r++)
            case (ph)
               0: csr_write(3'(r), 32'd65536);
               1: csr_write(3'(r), $urandom_range(1, 32'h0004_0000));
               2: csr_write(3'(r), (r == 5) ? 32'd0 : (r % 2) ? 32'hFFFF_FFFF : 32'd1);
               default: csr_write(3'(r), $urandom_range(32'h4000, 32'h0002_0000));
            endcase
         if (ph == 2) begin
            csr_write(3'd6, $urandom);      // indexes past the last register
            csr_write(3'd7, $urandom);
         end
         idle_pct  = idle_set[ph];
         stall_pct = stall_set[ph];
         random_traffic(ph == 0 ? 300 : 240, ph == 0, ph == 1);
         idle_pct  = 0;
         stall_pct = 0;
      end
      drain();

      $display("%0d requests: %0d queries, %0d hits, %0d commits refused on a full table, %0d clears",
               sent, table_model.queries, table_model.hits, table_model.refused,
               table_model.clears);
      $display("four traffic phases with cell sizes from 0 up to 0xFFFFFFFF, %0d mismatches",
               table_model.mismatches);
      if (table_model.mismatches == 0 && table_model.pending_rsp.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/rpl_pkg.sv
rtl/rpl_store.sv
rtl/region_penalty_lookup.sv
tb/sv/tb.sv
